@@ hdl/hma_pkg.sv @@
// ---------------------------------------------------------------------------
// hma_pkg: shared constants for the mouse report to ADB converter
// Field widths, motion limits and command, result and ctrl codes used by every file.
// ---------------------------------------------------------------------------
package hma_pkg;

  localparam int SUM_WIDTH_DEF = 16;
  localparam int DIVISOR_WIDTH = 8;
  localparam int DELTA_WIDTH   = 8;
  localparam int MOTION_WIDTH  = 7;
  localparam int BUTTON_WIDTH  = 8;

  // Limits of a 7-bit two's complement motion value.
  localparam int MOTION_MAX = 63;
  localparam int MOTION_MIN = -64;

  // Input command codes.
  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_POLL   = 1'b1;

  // Result kind codes.
  localparam logic KIND_MOTION = 1'b0;
  localparam logic KIND_CLICK  = 1'b1;

  // Ctrl key marker codes.
  localparam logic [1:0] CTRL_NONE    = 2'd0;
  localparam logic [1:0] CTRL_PRESS   = 2'd1;
  localparam logic [1:0] CTRL_RELEASE = 2'd2;

endpackage

@@ hdl/hma_div.sv @@
// ---------------------------------------------------------------------------
// hma_div: serial signed-by-unsigned divider
// Restoring divider, one quotient bit per cycle; quotient and remainder
// truncate toward zero and carry the sign of the dividend.
// ---------------------------------------------------------------------------
module hma_div #(
  parameter int SUM_WIDTH = hma_pkg::SUM_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [SUM_WIDTH-1:0]           dividend,
  input  logic [hma_pkg::DIVISOR_WIDTH-1:0]     divisor,
  output logic                                  done,
  output logic signed [SUM_WIDTH-1:0]           quotient,
  output logic signed [SUM_WIDTH-1:0]           remainder
);

  localparam int DW   = hma_pkg::DIVISOR_WIDTH;
  localparam int CNTW = (SUM_WIDTH > 1) ? $clog2(SUM_WIDTH) : 1;

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic            neg_r;
  logic [SUM_WIDTH-1:0] num_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   dsr_r;

  logic [DW:0]     trial;
  logic            q_bit;
  logic [DW:0]     diff;

  assign trial = {rem_r, num_r[SUM_WIDTH-1]};
  assign q_bit = (trial >= {1'b0, dsr_r});
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= dividend[SUM_WIDTH-1];
        num_r  <= dividend[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - dividend) : dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        num_r <= {num_r[SUM_WIDTH-2:0], q_bit};
        rem_r <= q_bit ? diff[DW-1:0] : trial[DW-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(SUM_WIDTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = neg_r ? (SUM_WIDTH'(0) - num_r) : num_r;
  assign remainder = neg_r ? (SUM_WIDTH'(0) - SUM_WIDTH'(rem_r)) : SUM_WIDTH'(rem_r);

endmodule

@@ hdl/hid_mouse_to_adb_motion_and_clicks.sv @@
// ---------------------------------------------------------------------------
// hid_mouse_to_adb_motion_and_clicks: USB mouse reports to ADB motion/clicks
// A poll runs four passes of the serial divider; a report that follows a poll
// first runs two passes for the two remainders. One request in flight at a time.
// Synchronous active-low reset clears accumulators, buttons, mode and divisor=1.
// ---------------------------------------------------------------------------
module hid_mouse_to_adb_motion_and_clicks #(
  parameter int SUM_WIDTH = hma_pkg::SUM_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Configuration: sensitivity divisor
  input  logic                                   cfg_write,
  input  logic [hma_pkg::DIVISOR_WIDTH-1:0]      cfg_data,
  // Input requests
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_command,
  input  logic [hma_pkg::BUTTON_WIDTH-1:0]       in_buttons,
  input  logic signed [hma_pkg::DELTA_WIDTH-1:0] in_delta_x,
  input  logic signed [hma_pkg::DELTA_WIDTH-1:0] in_delta_y,
  // Result requests
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_kind,
  output logic [hma_pkg::MOTION_WIDTH-1:0]       out_motion_x,
  output logic [hma_pkg::MOTION_WIDTH-1:0]       out_motion_y,
  output logic                                   out_click_left,
  output logic                                   out_click_right,
  output logic                                   out_click_middle,
  output logic [1:0]                             out_ctrl_action
);

  localparam int DW  = hma_pkg::DIVISOR_WIDTH;
  localparam int MW  = hma_pkg::MOTION_WIDTH;
  localparam int XW  = hma_pkg::DELTA_WIDTH;

  // Divider operand selectors. A poll walks all four in order; a report
  // that follows a poll only needs the two fine remainders.
  localparam logic [1:0] OP_COARSE_X = 2'd0;
  localparam logic [1:0] OP_FINE_X   = 2'd1;
  localparam logic [1:0] OP_COARSE_Y = 2'd2;
  localparam logic [1:0] OP_FINE_Y   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_START,
    S_DIV_WAIT,
    S_UPDATE,
    S_OUT
  } state_t;

  state_t state_r;

  logic [DW-1:0] cfg_div_r;
  logic [DW-1:0] div_eff;

  // Accumulators and button history.
  logic signed [SUM_WIDTH-1:0] coarse_x_r, coarse_y_r, fine_x_r, fine_y_r;
  logic [2:0] prev_btn_r;
  logic       ctrl_mode_r;
  logic       consumed_r;

  // Captured request.
  logic                 cmd_r;
  logic [2:0]           btn_r;
  logic signed [XW-1:0] dx_r, dy_r;

  // Sequencer bookkeeping.
  logic [1:0]                op_r;
  logic signed [SUM_WIDTH:0] acc_r;

  // Staged result, moved to the output register when it is free.
  logic          res_kind_r;
  logic [MW-1:0] res_mx_r, res_my_r;
  logic          res_left_r, res_right_r, res_middle_r;
  logic [1:0]    res_ctrl_r;

  // Output register.
  logic          out_valid_r;
  logic          out_kind_r;
  logic [MW-1:0] out_mx_r, out_my_r;
  logic          out_left_r, out_right_r, out_middle_r;
  logic [1:0]    out_ctrl_r;

  // Shared divider.
  logic                        div_start;
  logic                        div_done;
  logic signed [SUM_WIDTH-1:0] div_dividend;
  logic signed [SUM_WIDTH-1:0] div_quot, div_rem;

  logic in_accept;
  logic out_free;

  // Helpers for the report update.
  logic [XW:0]               mag_x, mag_y;
  logic                      small_x, small_y;
  logic signed [SUM_WIDTH:0] motion_total;
  logic                      l_now, r_now, m_now, l_chg, r_chg, mode_next;

  function automatic logic signed [SUM_WIDTH-1:0] sat_add(
    input logic signed [SUM_WIDTH-1:0] a,
    input logic signed [XW-1:0]        b
  );
    logic signed [SUM_WIDTH:0] s;
    s = {a[SUM_WIDTH-1], a} + {{(SUM_WIDTH + 1 - XW){b[XW-1]}}, b};
    if (s[SUM_WIDTH] != s[SUM_WIDTH-1]) begin
      return s[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end
    return s[SUM_WIDTH-1:0];
  endfunction

  function automatic logic [MW-1:0] clamp_motion(input logic signed [SUM_WIDTH:0] t);
    if (t > hma_pkg::MOTION_MAX) begin
      return MW'(hma_pkg::MOTION_MAX);
    end
    if (t < hma_pkg::MOTION_MIN) begin
      return MW'(hma_pkg::MOTION_MIN);
    end
    return t[MW-1:0];
  endfunction

  function automatic logic [XW:0] magnitude(input logic signed [XW-1:0] v);
    logic [XW:0] e;
    e = {v[XW-1], v};
    return v[XW-1] ? ((XW+1)'(0) - e) : e;
  endfunction

  // A divisor of zero behaves as one.
  assign div_eff = (cfg_div_r == '0) ? DW'(1) : cfg_div_r;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign div_start = (state_r == S_DIV_START);

  always_comb begin
    unique case (op_r)
      OP_COARSE_X: div_dividend = coarse_x_r;
      OP_FINE_X:   div_dividend = fine_x_r;
      OP_COARSE_Y: div_dividend = coarse_y_r;
      OP_FINE_Y:   div_dividend = fine_y_r;
      default:     div_dividend = coarse_x_r;
    endcase
  end

  hma_div #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_eff),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // A delta divides to zero exactly when its magnitude is below the divisor,
  // so the fine accumulators need a compare rather than a division.
  assign mag_x   = magnitude(dx_r);
  assign mag_y   = magnitude(dy_r);
  assign small_x = (mag_x < {1'b0, div_eff});
  assign small_y = (mag_y < {1'b0, div_eff});

  // Second quotient of an axis joins the first at full width before clamping.
  assign motion_total = acc_r + {div_quot[SUM_WIDTH-1], div_quot};

  // Button edges. A middle press toggles the mode, and the new mode already
  // applies to a right-button change in the same report.
  assign l_now     = btn_r[0];
  assign r_now     = btn_r[1];
  assign m_now     = btn_r[2];
  assign l_chg     = (l_now != prev_btn_r[0]);
  assign r_chg     = (r_now != prev_btn_r[1]);
  assign mode_next = ctrl_mode_r ^ (!prev_btn_r[2] && m_now);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_div_r   <= DW'(1);
      coarse_x_r  <= '0;
      coarse_y_r  <= '0;
      fine_x_r    <= '0;
      fine_y_r    <= '0;
      prev_btn_r  <= '0;
      ctrl_mode_r <= 1'b0;
      consumed_r  <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= OP_COARSE_X;
    end else begin
      if (cfg_write) begin
        cfg_div_r <= cfg_data;
      end

      // The output register is loaded from S_OUT once free; otherwise an
      // accepted result leaves it empty.
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            cmd_r <= in_command;
            btn_r <= in_buttons[2:0];
            dx_r  <= in_delta_x;
            dy_r  <= in_delta_y;
            if (in_command == hma_pkg::CMD_POLL) begin
              op_r    <= OP_COARSE_X;
              state_r <= S_DIV_START;
            end else if (consumed_r) begin
              // Reduce the fine sums to their remainders first.
              op_r    <= OP_FINE_X;
              state_r <= S_DIV_START;
            end else begin
              state_r <= S_UPDATE;
            end
          end
        end

        S_DIV_START: begin
          state_r <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_done) begin
            if (cmd_r == hma_pkg::CMD_POLL) begin
              unique case (op_r)
                OP_COARSE_X, OP_COARSE_Y: acc_r <= {div_quot[SUM_WIDTH-1], div_quot};
                OP_FINE_X:                res_mx_r <= clamp_motion(motion_total);
                OP_FINE_Y:                res_my_r <= clamp_motion(motion_total);
                default:                  acc_r <= acc_r;
              endcase
              if (op_r == OP_FINE_Y) begin
                res_kind_r   <= hma_pkg::KIND_MOTION;
                res_left_r   <= 1'b0;
                res_right_r  <= 1'b0;
                res_middle_r <= 1'b0;
                res_ctrl_r   <= hma_pkg::CTRL_NONE;
                consumed_r   <= 1'b1;
                state_r      <= S_OUT;
              end else begin
                op_r    <= op_r + 2'd1;
                state_r <= S_DIV_START;
              end
            end else begin
              if (op_r == OP_FINE_X) begin
                fine_x_r <= div_rem;
                op_r     <= OP_FINE_Y;
                state_r  <= S_DIV_START;
              end else begin
                fine_y_r   <= div_rem;
                coarse_x_r <= '0;
                coarse_y_r <= '0;
                consumed_r <= 1'b0;
                state_r    <= S_UPDATE;
              end
            end
          end
        end

        S_UPDATE: begin
          coarse_x_r <= sat_add(coarse_x_r, dx_r);
          coarse_y_r <= sat_add(coarse_y_r, dy_r);
          if (small_x) begin
            fine_x_r <= sat_add(fine_x_r, dx_r);
          end
          if (small_y) begin
            fine_y_r <= sat_add(fine_y_r, dy_r);
          end
          ctrl_mode_r <= mode_next;
          prev_btn_r  <= btn_r;

          res_kind_r   <= hma_pkg::KIND_CLICK;
          res_mx_r     <= '0;
          res_my_r     <= '0;
          res_middle_r <= m_now;
          if (r_chg && mode_next) begin
            // Ctrl-click: the right button stands in as a ctrl-held left click.
            res_left_r  <= r_now;
            res_right_r <= 1'b0;
            res_ctrl_r  <= r_now ? hma_pkg::CTRL_PRESS : hma_pkg::CTRL_RELEASE;
          end else begin
            res_left_r  <= l_now;
            res_right_r <= r_now;
            res_ctrl_r  <= hma_pkg::CTRL_NONE;
          end
          state_r <= (l_chg || r_chg) ? S_OUT : S_IDLE;
        end

        S_OUT: begin
          if (out_free) begin
            out_kind_r   <= res_kind_r;
            out_mx_r     <= res_mx_r;
            out_my_r     <= res_my_r;
            out_left_r   <= res_left_r;
            out_right_r  <= res_right_r;
            out_middle_r <= res_middle_r;
            out_ctrl_r   <= res_ctrl_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_motion_x     = out_mx_r;
  assign out_motion_y     = out_my_r;
  assign out_click_left   = out_left_r;
  assign out_click_right  = out_right_r;
  assign out_click_middle = out_middle_r;
  assign out_ctrl_action  = out_ctrl_r;

endmodule

@@ hdl/hma_checker.sv @@
// ---------------------------------------------------------------------------
// hma_checker: port-level checks for the mouse report to ADB converter
// Watches the top level's ports and flags bad input handshakes and inconsistent result requests.
// ---------------------------------------------------------------------------
module hma_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic                                   out_kind,
  input logic [hma_pkg::MOTION_WIDTH-1:0]       out_motion_x,
  input logic [hma_pkg::MOTION_WIDTH-1:0]       out_motion_y,
  input logic                                   out_click_left,
  input logic                                   out_click_right,
  input logic                                   out_click_middle,
  input logic [1:0]                             out_ctrl_action
);

  // A result held by the receiver stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  // An accepted request keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  // Motion results carry no button or ctrl information.
  a_motion_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == hma_pkg::KIND_MOTION |->
      !out_click_left && !out_click_right && !out_click_middle &&
      out_ctrl_action == hma_pkg::CTRL_NONE)
    else $error("motion result with click fields set");

  // Click events carry no motion.
  a_click_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == hma_pkg::KIND_CLICK |->
      out_motion_x == '0 && out_motion_y == '0)
    else $error("click event with motion set");

  // A ctrl marker pairs with a left click of the matching direction and no right click.
  a_ctrl_click: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ctrl_action != hma_pkg::CTRL_NONE |->
      !out_click_right &&
      ((out_ctrl_action == hma_pkg::CTRL_PRESS && out_click_left) ||
       (out_ctrl_action == hma_pkg::CTRL_RELEASE && !out_click_left)))
    else $error("ctrl marker inconsistent with click buttons");

endmodule

bind hid_mouse_to_adb_motion_and_clicks hma_checker u_hma_checker (.*);
